>>> sv/dms_pkg.sv
`timescale 1ns / 1ps
// dms_pkg: payload types and register codes for the debounced mode switch
// no dependencies; used by debounced_mode_switch and dms_checker

package dms_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_SWITCH_MODE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TICKS  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_QUICK_WINDOW_MS = 2'd2;

    localparam logic [2:0] MODE_DISABLED   = 3'd0;
    localparam logic [2:0] MODE_LANGUAGE   = 3'd1;
    localparam logic [2:0] MODE_MONO       = 3'd2;
    localparam logic [2:0] MODE_CYCLE      = 3'd3;
    localparam logic [2:0] MODE_LANG_MONO  = 3'd4;
    localparam logic [2:0] MODE_LANG_CYCLE = 3'd5;

    localparam logic [2:0]  SWITCH_MODE_RST     = MODE_DISABLED;
    localparam logic [3:0]  DEBOUNCE_TICKS_RST  = 4'd7;
    localparam logic [15:0] QUICK_WINDOW_MS_RST = 16'd1000;

    typedef struct packed {
        logic        switch_level;
        logic [31:0] now_ms;
        logic        color_supported;
        logic        menu_visible;
        logic        ignore_keypress;
    } in_t;

    typedef struct packed {
        logic       language_select;
        logic       forced_mono;
        logic       scanlines_on;
        logic [1:0] colour_mode;
        logic       show_mode_pulse;
        logic       menu_refresh;
    } out_t;

endpackage

>>> sv/debounced_mode_switch.sv
`timescale 1ns / 1ps
// debounced_mode_switch: switch debounce and display/language mode control
// depends on dms_pkg
//
//  channel | ports                           | moves
//  --------+---------------------------------+-------------------------------
//  input   | s_valid, s_ready, s_data        | one frame tick sample
//  result  | m_valid, m_ready, m_data        | flags, mode and pulses
//  config  | cfg_wr_en, cfg_index, cfg_wr_data | register write, no wait
//
// one transfer per cycle sustained while m_ready stays high; input register then
// result register, with all debounce and mode logic in the single stage between
// reset clears both stages' valid bits, the debounce state and flags, and loads the config registers with defaults
// input register refills while a result waits; s_ready drops only when both
// stages are full and m_ready is low

module debounced_mode_switch #(
    parameter int unsigned LAST_COLOUR_MODE = 2
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  dms_pkg::in_t                       s_data,

    output logic                               m_valid,
    input  logic                               m_ready,
    output dms_pkg::out_t                      m_data,

    input  logic                               cfg_wr_en,
    input  logic [dms_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dms_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    localparam int unsigned MW = $clog2(LAST_COLOUR_MODE + 1);
    localparam logic [MW-1:0] MODE_LAST = MW'(LAST_COLOUR_MODE);

    logic [2:0]    switch_mode_reg;
    logic [3:0]    debounce_ticks_reg;
    logic [15:0]   quick_window_ms_reg;

    logic          in_valid_reg;
    dms_pkg::in_t  in_data_reg;
    logic          out_valid_reg;
    dms_pkg::out_t out_data_reg;

    logic [4:0]    stable_count_reg,  stable_count_next;
    logic          stable_level_reg,  stable_level_next;
    logic          acted_level_reg,   acted_level_next;
    logic [31:0]   last_edge_ms_reg,  last_edge_ms_next;
    logic [MW-1:0] mode_index_reg,    mode_index_next;
    logic          mono_flag_reg,     mono_flag_next;
    logic          scanline_flag_reg, scanline_flag_next;
    logic          language_flag_reg, language_flag_next;
    dms_pkg::out_t out_data_next;

    logic          advance;
    logic          take_item;

    logic          lvl;
    logic [4:0]    count_inc;
    logic [4:0]    ticks_ext;
    logic          act;
    logic          edge_seen;
    logic          quick;
    logic [31:0]   elapsed;
    logic          show;
    logic          refresh;
    logic [MW-1:0] cyc_mode;
    logic          cyc_mono;
    logic          cyc_scan;
    logic          mode_at_last;

    assign advance   = !out_valid_reg || m_ready;
    assign take_item = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    // display-mode cycling
    always_comb begin
        mode_at_last = (mode_index_reg >= MODE_LAST);
        cyc_mode     = mode_index_reg;
        cyc_mono     = mono_flag_reg;
        cyc_scan     = scanline_flag_reg;
        if (in_data_reg.color_supported) begin
            if (mono_flag_reg) begin
                if (!mode_at_last) begin
                    cyc_mode = mode_index_reg + MW'(1);
                end else begin
                    cyc_mode = '0;
                    cyc_mono = 1'b0;
                end
            end else begin
                cyc_scan = !scanline_flag_reg;
                cyc_mono = 1'b1;
            end
        end else begin
            if (!mode_at_last) begin
                cyc_mode = mode_index_reg + MW'(1);
            end else begin
                cyc_mode = '0;
                cyc_scan = !scanline_flag_reg;
            end
        end
    end

    always_comb begin
        lvl                = in_data_reg.switch_level;
        ticks_ext          = {1'b0, debounce_ticks_reg};
        count_inc          = stable_count_reg + 5'd1;
        edge_seen          = (lvl != acted_level_reg);
        elapsed            = in_data_reg.now_ms - last_edge_ms_reg;
        quick              = (last_edge_ms_reg != 32'd0) &&
                             (elapsed < {16'd0, quick_window_ms_reg});
        act                = 1'b0;
        show               = 1'b0;
        refresh            = 1'b0;
        stable_count_next  = stable_count_reg;
        stable_level_next  = stable_level_reg;
        acted_level_next   = acted_level_reg;
        last_edge_ms_next  = last_edge_ms_reg;
        mode_index_next    = mode_index_reg;
        mono_flag_next     = mono_flag_reg;
        scanline_flag_next = scanline_flag_reg;
        language_flag_next = language_flag_reg;

        if (lvl != stable_level_reg || switch_mode_reg == dms_pkg::MODE_DISABLED) begin
            stable_count_next = '0;
            stable_level_next = lvl;
        end else if (count_inc > ticks_ext) begin
            stable_count_next = ticks_ext + 5'd1;
        end else begin
            stable_count_next = count_inc;
            act               = (count_inc == ticks_ext);
        end

        if (act) begin
            case (switch_mode_reg)
                dms_pkg::MODE_LANGUAGE: begin
                    language_flag_next = lvl;
                end
                dms_pkg::MODE_MONO: begin
                    mono_flag_next = lvl;
                    show           = 1'b1;
                end
                dms_pkg::MODE_CYCLE: begin
                    if (lvl && edge_seen) begin
                        mode_index_next    = cyc_mode;
                        mono_flag_next     = cyc_mono;
                        scanline_flag_next = cyc_scan;
                        show               = 1'b1;
                    end
                end
                dms_pkg::MODE_LANG_MONO: begin
                    language_flag_next = lvl;
                    if (edge_seen) begin
                        last_edge_ms_next = in_data_reg.now_ms;
                        if (quick) begin
                            mono_flag_next = !mono_flag_reg;
                            show           = 1'b1;
                        end
                    end
                end
                dms_pkg::MODE_LANG_CYCLE: begin
                    language_flag_next = lvl;
                    if (edge_seen) begin
                        last_edge_ms_next = in_data_reg.now_ms;
                        if (quick) begin
                            mode_index_next    = cyc_mode;
                            mono_flag_next     = cyc_mono;
                            scanline_flag_next = cyc_scan;
                            show               = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
            acted_level_next = lvl;
            refresh = in_data_reg.menu_visible &&
                      (switch_mode_reg != dms_pkg::MODE_LANGUAGE) &&
                      !in_data_reg.ignore_keypress;
        end

        out_data_next.language_select = language_flag_next;
        out_data_next.forced_mono     = mono_flag_next;
        out_data_next.scanlines_on    = scanline_flag_next;
        out_data_next.colour_mode     = 2'(mode_index_next);
        out_data_next.show_mode_pulse = show;
        out_data_next.menu_refresh    = refresh;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            switch_mode_reg     <= dms_pkg::SWITCH_MODE_RST;
            debounce_ticks_reg  <= dms_pkg::DEBOUNCE_TICKS_RST;
            quick_window_ms_reg <= dms_pkg::QUICK_WINDOW_MS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                dms_pkg::REG_SWITCH_MODE:     switch_mode_reg     <= cfg_wr_data[2:0];
                dms_pkg::REG_DEBOUNCE_TICKS:  debounce_ticks_reg  <= cfg_wr_data[3:0];
                dms_pkg::REG_QUICK_WINDOW_MS: quick_window_ms_reg <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg     <= 1'b0;
            stable_count_reg  <= '0;
            stable_level_reg  <= 1'b0;
            acted_level_reg   <= 1'b0;
            last_edge_ms_reg  <= '0;
            mode_index_reg    <= '0;
            mono_flag_reg     <= 1'b0;
            scanline_flag_reg <= 1'b0;
            language_flag_reg <= 1'b0;
        end else begin
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (take_item) begin
                stable_count_reg  <= stable_count_next;
                stable_level_reg  <= stable_level_next;
                acted_level_reg   <= acted_level_next;
                last_edge_ms_reg  <= last_edge_ms_next;
                mode_index_reg    <= mode_index_next;
                mono_flag_reg     <= mono_flag_next;
                scanline_flag_reg <= scanline_flag_next;
                language_flag_reg <= language_flag_next;
            end
        end
        if (take_item) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

>>> sv/dms_checker.sv
`timescale 1ns / 1ps
// dms_checker: port-level checks for debounced_mode_switch, bound into every instance of it
// depends on dms_pkg

module dms_checker #(
    parameter int unsigned LAST_COLOUR_MODE = 2
) (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input dms_pkg::out_t m_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // input side stalls only when the result stage is full and stalled
    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled while result stage free");

    // display state changes only with a show-mode pulse
    a_mode_change_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(m_valid && m_ready) && m_valid |->
            m_data.show_mode_pulse ||
            (m_data.forced_mono  == $past(m_data.forced_mono) &&
             m_data.scanlines_on == $past(m_data.scanlines_on) &&
             m_data.colour_mode  == $past(m_data.colour_mode)))
        else $error("display mode changed without show pulse");

    // colour index stays within range where the port shows it whole
    a_colour_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (LAST_COLOUR_MODE > 3) ||
            (32'(m_data.colour_mode) <= LAST_COLOUR_MODE))
        else $error("colour mode out of range");

endmodule

bind debounced_mode_switch dms_checker #(
    .LAST_COLOUR_MODE(LAST_COLOUR_MODE)
) u_dms_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
